/* hdl/fvta_pkg.sv */
// Shared types and constants of the flow VLAN tag assigner.
`timescale 1ns / 1ps

package fvta_pkg;

    localparam int TAG_W   = 12;
    localparam int ENTRY_W = 12;
    localparam int COUNT_W = 32;
    localparam int MAP_W   = 64;
    localparam int KIND_W  = 2;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_IPV4  = 2'd0;
    localparam kind_t KIND_VLAN  = 2'd1;
    localparam kind_t KIND_OTHER = 2'd2;

    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_VLAN = 16'h8100;

    localparam logic [TAG_W-1:0]   FIRST_TAG     = 12'h001;
    localparam logic [TAG_W-1:0]   LAST_TAG_MARK = 12'hFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 32'hFFFF_FFFF;

    // One classified item between the front end and the table engine
    typedef struct packed {
        kind_t               kind;
        logic [ENTRY_W-1:0]  entry;
    } fvta_item_t;

endpackage

/* hdl/fvta_front.sv */
// Front end: accepts descriptors, classifies the ethertype and reduces the flow index.
`timescale 1ns / 1ps

module fvta_front #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic                desc_valid,
    output logic                desc_ready,
    input  logic [15:0]         frame_type,
    input  logic                flow_found,
    input  logic [15:0]         flow_index,
    output logic                push_valid,
    input  logic                push_ready,
    output fvta_pkg::fvta_item_t push_item
);
    import fvta_pkg::*;

    // Reciprocal of the table size; the estimate it gives is low by at most one
    localparam logic [31:0] RECIP = (TABLE_ENTRIES == 1) ? 32'hFFFF_FFFF
                                  : 32'(64'h1_0000_0000 / TABLE_ENTRIES);
    localparam logic [15:0] DIV   = 16'(TABLE_ENTRIES);

    logic        s1_valid_reg, s1_valid_next;
    kind_t       s1_kind_reg;
    logic [15:0] s1_x_reg;

    logic        s2_valid_reg, s2_valid_next;
    kind_t       s2_kind_reg;
    logic [15:0] s2_x_reg;
    logic [15:0] s2_q_reg;

    kind_t       kind_in;
    logic [47:0] prod;
    logic [15:0] rem_raw;
    logic [15:0] rem;
    logic        accept;
    logic        s1_move;
    logic        s2_move;

    always_comb
    begin
        case (frame_type)
            TYPE_IPV4: kind_in = KIND_IPV4;
            TYPE_VLAN: kind_in = KIND_VLAN;
            default:   kind_in = KIND_OTHER;
        endcase
    end

    assign s2_move    = s2_valid_reg && push_ready;
    assign s1_move    = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign desc_ready = enable && (!s1_valid_reg || s1_move);
    assign accept     = desc_valid && desc_ready;

    assign prod    = 48'(s1_x_reg) * 48'(RECIP);
    assign rem_raw = s2_x_reg - 16'(32'(s2_q_reg) * 32'(DIV));
    assign rem     = (rem_raw >= DIV) ? (rem_raw - DIV) : rem_raw;

    assign push_valid      = s2_valid_reg;
    assign push_item.kind  = s2_kind_reg;
    assign push_item.entry = (s2_kind_reg == KIND_IPV4) ? rem[ENTRY_W-1:0] : '0;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        s2_valid_next = s2_valid_reg;
        if (s1_move)
            s2_valid_next = 1'b1;
        else if (s2_move)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind_in;
            // no flow found: use entry 0
            s1_x_reg    <= flow_found ? flow_index : 16'd0;
        end
        if (s1_move)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_x_reg    <= s1_x_reg;
            s2_q_reg    <= prod[47:32];
        end
    end

endmodule

/* hdl/fvta_queue.sv */
// Two-entry queue between the front end and the table engine.
`timescale 1ns / 1ps

module fvta_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  fvta_pkg::fvta_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output fvta_pkg::fvta_item_t pop_item
);
    import fvta_pkg::*;

    fvta_item_t slot_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* hdl/fvta_back.sv */
// Table engine: read-modify-write of the per-entry tag and count, dirty map, result register.
`timescale 1ns / 1ps

module fvta_back #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int HEADER_BYTES  = 8,
    parameter int ENTRY_BYTES   = 16,
    parameter int CHUNK_BYTES   = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          init_done,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  fvta_pkg::fvta_item_t          pop_item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output fvta_pkg::kind_t               frame_kind,
    output logic [fvta_pkg::TAG_W-1:0]    assigned_tag,
    output logic [fvta_pkg::ENTRY_W-1:0]  entry_num,
    output logic [fvta_pkg::COUNT_W-1:0]  entry_packets,
    output logic [fvta_pkg::MAP_W-1:0]    dirty_map
);
    import fvta_pkg::*;

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);
    localparam int OFF_W = 24;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [TAG_W-1:0]   tag_mem [0:TABLE_ENTRIES-1];
    logic [COUNT_W-1:0] cnt_mem [0:TABLE_ENTRIES-1];

    logic [1:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [TAG_W-1:0]   next_tag_reg, next_tag_next;
    logic [MAP_W-1:0]   dirty_reg, dirty_next;

    kind_t              cur_kind_reg;
    logic [ENTRY_W-1:0] cur_entry_reg;
    logic [TAG_W-1:0]   rd_tag_reg;
    logic [COUNT_W-1:0] rd_cnt_reg;

    logic               res_valid_reg, res_valid_next;
    kind_t              res_kind_reg;
    logic [TAG_W-1:0]   res_tag_reg;
    logic [ENTRY_W-1:0] res_entry_reg;
    logic [COUNT_W-1:0] res_cnt_reg;
    logic [MAP_W-1:0]   res_map_reg;

    logic               do_pop;
    logic               finish;
    logic               is_ipv4;
    logic [TAG_W-1:0]   drawn_tag;
    logic [TAG_W-1:0]   new_tag;
    logic [COUNT_W-1:0] new_cnt;
    logic [OFF_W-1:0]   span_start;
    logic [OFF_W-1:0]   span_stop;
    logic [MAP_W-1:0]   span_mask;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [TAG_W-1:0]   mem_wtag;
    logic [COUNT_W-1:0] mem_wcnt;

    function automatic logic in_chunk(input logic [OFF_W-1:0] off, input int k);
        logic [OFF_W-1:0] lo;
        logic [OFF_W-1:0] hi;
        lo = OFF_W'(k * CHUNK_BYTES);
        hi = OFF_W'((k + 1) * CHUNK_BYTES);
        return (off >= lo) && (off < hi);
    endfunction

    assign init_done = (state_reg != ST_CLEAR);
    assign pop_ready = (state_reg == ST_IDLE);
    assign do_pop    = pop_valid && pop_ready;
    // hold the update while the previous result still waits
    assign finish    = (state_reg == ST_UPDATE) && (!res_valid_reg || res_ready);
    assign is_ipv4   = (cur_kind_reg == KIND_IPV4);

    // wrap the allocator before drawing, so 0 and 0xFFF are never given
    assign drawn_tag = (next_tag_reg inside {12'h000, LAST_TAG_MARK}) ? FIRST_TAG
                                                                     : next_tag_reg;

    always_comb
    begin
        if (rd_tag_reg != '0)
        begin
            new_tag = rd_tag_reg;
            new_cnt = (rd_cnt_reg == COUNT_MAX) ? rd_cnt_reg : rd_cnt_reg + 32'd1;
        end
        else
        begin
            new_tag = drawn_tag;
            new_cnt = 32'd1;
        end
    end

    assign span_start = OFF_W'(HEADER_BYTES) + OFF_W'(cur_entry_reg) * OFF_W'(ENTRY_BYTES);
    assign span_stop  = span_start + OFF_W'(ENTRY_BYTES);

    always_comb
    begin
        for (int k = 0; k < MAP_W; k++)
            span_mask[k] = in_chunk(span_start, k) || in_chunk(span_stop, k);
    end

    always_comb
    begin
        next_tag_next = next_tag_reg;
        dirty_next    = dirty_reg;
        if (finish && is_ipv4)
        begin
            if (rd_tag_reg == '0)
                next_tag_next = drawn_tag + 12'd1;
            dirty_next = dirty_reg | span_mask;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (do_pop)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (finish)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            next_tag_reg  <= FIRST_TAG;
            dirty_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_tag_reg  <= next_tag_next;
            dirty_reg     <= dirty_next;
            res_valid_reg <= res_valid_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            cur_kind_reg  <= pop_item.kind;
            cur_entry_reg <= pop_item.entry;
        end
        if (finish)
        begin
            res_kind_reg  <= cur_kind_reg;
            res_tag_reg   <= is_ipv4 ? new_tag : '0;
            res_entry_reg <= is_ipv4 ? cur_entry_reg : '0;
            res_cnt_reg   <= is_ipv4 ? new_cnt : '0;
            res_map_reg   <= dirty_next;
        end
    end

    // table write: clearing pass after reset, else the update of an IPv4 item
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wtag  = '0;
            mem_wcnt  = '0;
        end
        else
        begin
            mem_we    = finish && is_ipv4;
            mem_waddr = cur_entry_reg[ADDR_W-1:0];
            mem_wtag  = new_tag;
            mem_wcnt  = new_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= mem_wtag;
            cnt_mem[mem_waddr] <= mem_wcnt;
        end
        if (do_pop)
        begin
            rd_tag_reg <= tag_mem[pop_item.entry[ADDR_W-1:0]];
            rd_cnt_reg <= cnt_mem[pop_item.entry[ADDR_W-1:0]];
        end
    end

    assign res_valid     = res_valid_reg;
    assign frame_kind    = res_kind_reg;
    assign assigned_tag  = res_tag_reg;
    assign entry_num     = res_entry_reg;
    assign entry_packets = res_cnt_reg;
    assign dirty_map     = res_map_reg;

endmodule

/* hdl/flow_vlan_tag_assigner_unit.sv */
// Top level of the flow VLAN tag assigner: front end, queue and table engine.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------------
//  desc     | desc_valid, desc_ready | frame_type, flow_found, flow_index
//  res      | res_valid, res_ready   | frame_kind, assigned_tag, entry_num,
//           |                        | entry_packets, dirty_map
//
//  The table engine reads an entry when it takes the item and writes it back in its
//  update state before it takes the next. Front end stages s1 and s2 do index reduction.
//  After reset a clearing pass writes all TABLE_ENTRIES entries, one a cycle;
//  desc_ready stays low until the clearing pass is done.
//  A stalled result holds the table engine; the queue and front end keep taking
//  items until they fill.
`timescale 1ns / 1ps

module flow_vlan_tag_assigner_unit #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int HEADER_BYTES  = 8,
    parameter int ENTRY_BYTES   = 16,
    parameter int CHUNK_BYTES   = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          desc_valid,
    output logic                          desc_ready,
    input  logic [15:0]                   frame_type,
    input  logic                          flow_found,
    input  logic [15:0]                   flow_index,
    output logic                          res_valid,
    input  logic                          res_ready,
    output fvta_pkg::kind_t               frame_kind,
    output logic [fvta_pkg::TAG_W-1:0]    assigned_tag,
    output logic [fvta_pkg::ENTRY_W-1:0]  entry_num,
    output logic [fvta_pkg::COUNT_W-1:0]  entry_packets,
    output logic [fvta_pkg::MAP_W-1:0]    dirty_map
);
    import fvta_pkg::*;

    logic       init_done;
    logic       push_valid, push_ready;
    fvta_item_t push_item;
    logic       pop_valid, pop_ready;
    fvta_item_t pop_item;

    fvta_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (init_done),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .frame_type (frame_type),
        .flow_found (flow_found),
        .flow_index (flow_index),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fvta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fvta_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .HEADER_BYTES (HEADER_BYTES),
        .ENTRY_BYTES  (ENTRY_BYTES),
        .CHUNK_BYTES  (CHUNK_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .init_done     (init_done),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .frame_kind    (frame_kind),
        .assigned_tag  (assigned_tag),
        .entry_num     (entry_num),
        .entry_packets (entry_packets),
        .dirty_map     (dirty_map)
    );

`ifndef ASSERT_OFF
    // no item enters while the table is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (desc_valid && desc_ready) |-> init_done)
        else $error("item accepted during table clearing");

    // an IPv4 result carries a valid tag and a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && frame_kind == KIND_IPV4) |->
        (assigned_tag != '0 && assigned_tag != LAST_TAG_MARK && entry_packets != '0))
        else $error("IPv4 result with bad tag or count");

    // other frames report only their kind and the map
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && frame_kind != KIND_IPV4) |->
        (assigned_tag == '0 && entry_num == '0 && entry_packets == '0))
        else $error("non-IPv4 result with entry fields set");

    // entry stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({1'b0, entry_num} < 13'(TABLE_ENTRIES)))
        else $error("entry index beyond table");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the flow VLAN tag assigner unit.
`timescale 1ns / 1ps

module tb_top;

    import fvta_pkg::*;

    localparam int TABLE_ENTRIES = 4096;
    localparam int HEADER_BYTES  = 8;
    localparam int ENTRY_BYTES   = 16;
    localparam int CHUNK_BYTES   = 1024;

    typedef struct {
        kind_t               kind;
        logic [TAG_W-1:0]    tag;
        logic [ENTRY_W-1:0]  entry;
        logic [COUNT_W-1:0]  packets;
        logic [MAP_W-1:0]    dirty;
    } tag_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  desc_valid = 1'b0;
    logic                  desc_ready;
    logic [15:0]           frame_type = 16'h0000;
    logic                  flow_found = 1'b0;
    logic [15:0]           flow_index = 16'h0000;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    kind_t                 frame_kind;
    logic [TAG_W-1:0]      assigned_tag;
    logic [ENTRY_W-1:0]    entry_num;
    logic [COUNT_W-1:0]    entry_packets;
    logic [MAP_W-1:0]      dirty_map;

    // Mirror of the block's flow state
    logic [TAG_W-1:0]      flow_tag_tbl [TABLE_ENTRIES];
    logic [COUNT_W-1:0]    flow_pkt_tbl [TABLE_ENTRIES];
    logic [TAG_W-1:0]      tag_alloc_next;
    logic [MAP_W-1:0]      dirty_acc;

    tag_result_t           tag_result_q [$];

    int                    fail_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_request = 0;
    int                    hold_left = 0;

    flow_vlan_tag_assigner_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HEADER_BYTES  (HEADER_BYTES),
        .ENTRY_BYTES   (ENTRY_BYTES),
        .CHUNK_BYTES   (CHUNK_BYTES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .desc_valid    (desc_valid),
        .desc_ready    (desc_ready),
        .frame_type    (frame_type),
        .flow_found    (flow_found),
        .flow_index    (flow_index),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .frame_kind    (frame_kind),
        .assigned_tag  (assigned_tag),
        .entry_num     (entry_num),
        .entry_packets (entry_packets),
        .dirty_map     (dirty_map)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [MAP_W-1:0] chunk_mask(input int offset);
        int pos;
        begin
            pos = offset / CHUNK_BYTES;
            // drop chunks past the end of the map
            if (pos >= MAP_W)
                return '0;
            return 64'd1 << pos;
        end
    endfunction

    // Update the mirrored state for one descriptor and queue its result
    task automatic assign_vlan_tag(input logic [15:0] etype, input logic found,
                                   input logic [15:0] findex);
        tag_result_t r;
        int          e;
        int          start_byte;
        logic [TAG_W-1:0] stored;
        logic [TAG_W-1:0] tag;
        begin
            r.tag     = '0;
            r.entry   = '0;
            r.packets = '0;
            if (etype == TYPE_IPV4) begin
                e = found ? (int'(findex) % TABLE_ENTRIES) : 0;
                stored = flow_tag_tbl[e];
                if (stored != '0) begin
                    tag = stored;
                end
                else begin
                    tag = tag_alloc_next;
                    if (tag >= LAST_TAG_MARK || tag == '0)
                        tag = FIRST_TAG;
                    tag_alloc_next = tag + 1'b1;
                end
                if (stored != tag) begin
                    flow_tag_tbl[e] = tag;
                    flow_pkt_tbl[e] = 32'd1;
                end
                else if (flow_pkt_tbl[e] != COUNT_MAX) begin
                    flow_pkt_tbl[e] = flow_pkt_tbl[e] + 1'b1;
                end
                start_byte = HEADER_BYTES + e * ENTRY_BYTES;
                dirty_acc = dirty_acc | chunk_mask(start_byte)
                          | chunk_mask(start_byte + ENTRY_BYTES);
                r.kind    = KIND_IPV4;
                r.tag     = tag;
                r.entry   = e[ENTRY_W-1:0];
                r.packets = flow_pkt_tbl[e];
            end
            else if (etype == TYPE_VLAN) begin
                r.kind = KIND_VLAN;
            end
            else begin
                r.kind = KIND_OTHER;
            end
            r.dirty = dirty_acc;
            tag_result_q.push_back(r);
        end
    endtask

    // Offer one descriptor; returns once it is accepted, with valid left high
    task automatic send_desc(input logic [15:0] etype, input logic found,
                             input logic [15:0] findex);
        int gap;
        begin
            gap = 0;
            while ($urandom_range(99) < send_idle_pct)
                gap++;
            if (gap > 0) begin
                desc_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            desc_valid <= 1'b1;
            frame_type <= etype;
            flow_found <= found;
            flow_index <= findex;
            do
                @(posedge clk);
            while (!desc_ready);
            assign_vlan_tag(etype, found, findex);
        end
    endtask

    // Hold the sender until every queued result has come back
    task automatic wait_drain();
        begin
            desc_valid <= 1'b0;
            while (tag_result_q.size() != 0)
                @(posedge clk);
            repeat (6) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [MAP_W-1:0] exp_val,
                               input logic [MAP_W-1:0] act_val);
        begin
            if (exp_val !== act_val) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        tag_result_t exp_r;
        if (rst_n && res_valid && res_ready) begin
            if (tag_result_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual kind %0d tag %0h",
                         $time, frame_kind, assigned_tag);
                fail_count++;
            end
            else begin
                exp_r = tag_result_q.pop_front();
                check_field("frame_kind", MAP_W'(exp_r.kind), MAP_W'(frame_kind));
                check_field("assigned_tag", MAP_W'(exp_r.tag), MAP_W'(assigned_tag));
                check_field("entry_num", MAP_W'(exp_r.entry), MAP_W'(entry_num));
                check_field("entry_packets", MAP_W'(exp_r.packets), MAP_W'(entry_packets));
                check_field("dirty_map", exp_r.dirty, dirty_map);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            res_ready <= 1'b0;
            hold_left--;
        end
        else begin
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            send_desc(TYPE_IPV4, 1'b0, 16'hFFFF);   // no flow: entry 0
            send_desc(TYPE_IPV4, 1'b1, 16'h0000);   // reuse entry 0
            send_desc(TYPE_IPV4, 1'b1, 16'h1000);   // wraps onto entry 0
            send_desc(TYPE_IPV4, 1'b1, 16'hFFFF);   // last entry, end chunk dropped
            send_desc(TYPE_IPV4, 1'b1, 16'h0FFF);
            send_desc(TYPE_IPV4, 1'b1, 16'd63);     // span crosses a chunk boundary
            send_desc(TYPE_IPV4, 1'b1, 16'd64);
            send_desc(TYPE_IPV4, 1'b1, 16'd2047);
            send_desc(TYPE_IPV4, 1'b0, 16'h0000);
            send_desc(TYPE_VLAN, 1'b1, 16'h0005);
            send_desc(TYPE_VLAN, 1'b0, 16'hFFFF);
            send_desc(16'h0000, 1'b1, 16'h0001);
            send_desc(16'hFFFF, 1'b1, 16'hFFFF);
            send_desc(16'h0801, 1'b1, 16'h0002);
            send_desc(16'h8000, 1'b0, 16'h0003);
            send_desc(16'h07FF, 1'b1, 16'h0004);
            send_desc(16'h8101, 1'b1, 16'h0005);
            send_desc(TYPE_IPV4, 1'b1, 16'h0005);
            wait_drain();
        end
    endtask

    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        int          k;
        int          pick;
        logic [15:0] etype;
        logic [15:0] findex;
        begin
            send_idle_pct = idle_pct;
            recv_stall_pct = stall_pct;
            for (k = 0; k < n_items; k++) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    etype = TYPE_IPV4;
                else if (pick < 80)
                    etype = TYPE_VLAN;
                else
                    etype = 16'($urandom_range(16'hFFFF));
                findex = 16'($urandom_range(16'hFFFF));
                // revisit a few hot entries so counts climb
                if ($urandom_range(1) == 0)
                    findex[11:0] = 12'($urandom_range(31));
                send_desc(etype, 1'($urandom_range(1)), findex);
            end
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        int k;
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_request = 300;
            for (k = 0; k < 40; k++)
                send_desc(TYPE_IPV4, 1'b1, 16'($urandom_range(16'hFFFF)));
            wait_drain();
        end
    endtask

    // Walk entries spread over the whole table, most of them still untagged
    task automatic test_entry_sweep();
        int          e;
        logic [15:0] findex;
        begin
            send_idle_pct = 10;
            recv_stall_pct = 10;
            for (e = 0; e < 400; e++) begin
                findex[15:12] = 4'($urandom_range(15));
                findex[11:0] = 12'(e * 10);
                send_desc(TYPE_IPV4, (e != 0) || ($urandom_range(1) == 1), findex);
            end
            for (e = 0; e < 8; e++)
                send_desc(TYPE_IPV4, 1'b1, 16'($urandom_range(16'hFFFF)));
            wait_drain();
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            flow_tag_tbl[i] = '0;
            flow_pkt_tbl[i] = '0;
        end
        tag_alloc_next = FIRST_TAG;
        dirty_acc = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(300, 0, 0);
        test_random(250, 76, 0);
        test_random(250, 0, 76);
        test_random(250, 33, 33);
        test_backpressure();
        test_random(150, 0, 0);
        test_entry_sweep();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
